[hdl/csl_pkg.sv]
// Package for the C#-subset lexer: lexer modes, token kinds, word layout and
// character class and keyword helper functions. Depends on nothing.
`timescale 1ns / 1ps
package csl_pkg;

    localparam int TOKEN_LIMIT = 1024;
    localparam int POS_BITS    = 16;
    localparam int CNT_BITS    = $clog2(TOKEN_LIMIT + 1);

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_LINE, M_BLOCK, M_STAR, M_HELD, M_DEAD
    } t_mode;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_INT    = 6'd1;
    localparam logic [5:0] K_STRING = 6'd2;
    localparam logic [5:0] K_IDENT  = 6'd3;
    localparam logic [5:0] K_KW0    = 6'd4;

    typedef struct packed {
        logic        last;
        logic        err;
        logic [31:0] ival;
        logic [15:0] len;
        logic [15:0] pos;
        logic [5:0]  kind;
    } t_tok;

    typedef struct packed {
        logic [5:0]  kind;
        t_pos        pos;
        t_pos        len;
        logic [31:0] ival;
    } t_emit;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
    endfunction

    function automatic logic [5:0] held_single(input logic [7:0] h);
        case (h)
            8'h3d: return 6'd25;
            8'h21: return 6'd34;
            8'h3c: return 6'd28;
            8'h3e: return 6'd29;
            8'h2b: return 6'd20;
            8'h2d: return 6'd21;
            8'h2f: return 6'd23;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] held_pair(input logic [7:0] h, input logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        if (c == 8'h3d) begin
            case (h)
                8'h3d: k = 6'd26;
                8'h21: k = 6'd27;
                8'h3c: k = 6'd30;
                8'h3e: k = 6'd31;
                8'h2b: k = 6'd37;
                8'h2d: k = 6'd38;
                default: k = 6'd0;
            endcase
        end
        if (c == h) begin
            case (h)
                8'h26: k = 6'd32;
                8'h7c: k = 6'd33;
                8'h2b: k = 6'd35;
                8'h2d: k = 6'd36;
                default: ;
            endcase
        end
        return k;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            8'h2a: return 6'd22;
            8'h25: return 6'd24;
            8'h28: return 6'd39;
            8'h29: return 6'd40;
            8'h7b: return 6'd41;
            8'h7d: return 6'd42;
            8'h5b: return 6'd43;
            8'h5d: return 6'd44;
            8'h3b: return 6'd45;
            8'h2c: return 6'd46;
            8'h2e: return 6'd47;
            default: return 6'd0;
        endcase
    endfunction

    // Keywords packed first character in the lowest byte; only the low n bytes are compared.
    function automatic logic [5:0] kw_kind(input logic [47:0] w, input logic [2:0] n);
        logic [5:0] k;
        k = K_IDENT;
        case (n)
            3'd2: if (w[15:0] == "fi") k = 6'd11;
            3'd3: begin
                if (w[23:0] == "tni") k = 6'd8;
                else if (w[23:0] == "rof") k = 6'd14;
                else if (w[23:0] == "wen") k = 6'd19;
            end
            3'd4: begin
                if (w[31:0] == "diov") k = 6'd7;
                else if (w[31:0] == "loob") k = 6'd10;
                else if (w[31:0] == "esle") k = 6'd12;
                else if (w[31:0] == "eurt") k = 6'd16;
                else if (w[31:0] == "llun") k = 6'd18;
            end
            3'd5: begin
                if (w[39:0] == "gnisu") k = 6'd4;
                else if (w[39:0] == "ssalc") k = 6'd5;
                else if (w[39:0] == "elihw") k = 6'd13;
                else if (w[39:0] == "eslaf") k = 6'd17;
            end
            3'd6: begin
                if (w == "citats") k = 6'd6;
                else if (w == "gnirts") k = 6'd9;
                else if (w == "nruter") k = 6'd15;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

[hdl/csl_out_buf.sv]
// Four-entry result queue between the lexer core and the master stream port.
// Depends on csl_pkg.
`timescale 1ns / 1ps
module csl_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_a,
    input  csl_pkg::t_tok i_tok_a,
    input  logic          i_wr_b,
    input  csl_pkg::t_tok i_tok_b,
    output logic          o_room,
    output logic          o_valid,
    output csl_pkg::t_tok o_tok,
    input  logic          i_ready
);
    import csl_pkg::*;

    t_tok       r_q [4];
    logic [1:0] r_rd;
    logic [1:0] r_wr;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = r_cnt != 3'd0;
    assign o_tok   = r_q[r_rd];
    assign o_room  = (r_cnt + {2'd0, i_wr_a} + {2'd0, i_wr_b}) <= 3'd2;
    assign n_cnt   = r_cnt + {2'd0, i_wr_a} + {2'd0, i_wr_b} - {2'd0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 2'd0;
            r_wr  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_pop) r_rd <= r_rd + 2'd1;
            r_wr <= r_wr + {1'b0, i_wr_a} + {1'b0, i_wr_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_a) r_q[r_wr] <= i_tok_a;
        if (i_wr_b) r_q[r_wr + {1'b0, i_wr_a}] <= i_tok_b;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("result queue overflow");
    a_b_needs_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_b |-> i_wr_a) else $error("second result without first");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_wr_a) |=> r_cnt == $past(r_cnt) - 3'd1) else $error("count slip");
endmodule

[hdl/csl_core.sv]
// Lexer state and per-byte decision logic; produces up to two results per word.
// Depends on csl_pkg.
`timescale 1ns / 1ps
module csl_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic          i_end,
    input  logic [7:0]    i_c,
    output logic          o_wr_a,
    output csl_pkg::t_tok o_tok_a,
    output logic          o_wr_b,
    output csl_pkg::t_tok o_tok_b
);
    import csl_pkg::*;

    t_mode       r_mode, n_mode;
    logic [7:0]  r_held, n_held;
    logic [47:0] r_word, n_word;
    logic [2:0]  r_wlen, n_wlen;
    t_pos        r_start, n_start;
    t_pos        r_bpos, n_bpos;
    logic [31:0] r_acc, n_acc;
    t_cnt        r_cnt, n_cnt;

    logic        e1, e2, er, fresh;
    t_emit       t1, t2;
    logic [5:0]  k;
    t_pos        er_pos;
    logic [31:0] acc10;
    logic [1:0]  ntok;
    logic        ok1, ok2;

    assign acc10 = {r_acc[28:0], 3'b0} + {r_acc[30:0], 1'b0};

    always_comb begin
        n_mode = r_mode; n_held = r_held; n_word = r_word; n_wlen = r_wlen;
        n_start = r_start; n_acc = r_acc; n_bpos = r_bpos + t_pos'(1);
        e1 = 1'b0; e2 = 1'b0; er = 1'b0; fresh = 1'b0; er_pos = r_start;
        t1 = '0; t2 = '0; k = '0;
        if (i_end) begin
            n_bpos = r_bpos;
            case (r_mode)
                M_IDENT: begin
                    e1 = 1'b1;
                    t1 = '{kw_kind(r_word, r_wlen), r_start, r_bpos - r_start, 32'd0};
                end
                M_NUMBER: begin
                    e1 = 1'b1; t1 = '{K_INT, r_start, r_bpos - r_start, r_acc};
                end
                M_STRING: begin
                    e1 = 1'b1; t1 = '{K_STRING, r_start, r_bpos - r_start, 32'd0};
                end
                M_HELD: begin
                    k = held_single(r_held);
                    if (k == 6'd0) er = 1'b1;
                    else begin
                        e1 = 1'b1; t1 = '{k, r_start, t_pos'(1), 32'd0};
                    end
                end
                default: ;
            endcase
            if (r_mode != M_DEAD && !er) begin
                e2 = 1'b1; t2 = '{K_EOF, r_bpos, t_pos'(0), 32'd0};
            end
        end else begin
            case (r_mode)
                M_DEAD: ;
                M_IDENT: begin
                    if (is_letter(i_c) || is_num(i_c)) begin
                        if (r_wlen < 3'd6) n_word[r_wlen*8 +: 8] = i_c;
                        if (r_wlen < 3'd7) n_wlen = r_wlen + 3'd1;
                    end else begin
                        e1 = 1'b1; fresh = 1'b1;
                        t1 = '{kw_kind(r_word, r_wlen), r_start, r_bpos - r_start, 32'd0};
                    end
                end
                M_NUMBER: begin
                    if (is_num(i_c)) n_acc = acc10 + {28'd0, i_c[3:0]};
                    else begin
                        e1 = 1'b1; fresh = 1'b1;
                        t1 = '{K_INT, r_start, r_bpos - r_start, r_acc};
                    end
                end
                M_STRING: if (i_c == 8'h22) begin
                    e1 = 1'b1; n_mode = M_IDLE;
                    t1 = '{K_STRING, r_start, r_bpos - r_start, 32'd0};
                end
                M_LINE: if (i_c == 8'h0a) n_mode = M_IDLE;
                M_BLOCK: if (i_c == 8'h2a) n_mode = M_STAR;
                M_STAR: begin
                    if (i_c == 8'h2f) n_mode = M_IDLE;
                    else if (i_c != 8'h2a) n_mode = M_BLOCK;
                end
                M_HELD: begin
                    if (r_held == 8'h2f && i_c == 8'h2f) n_mode = M_LINE;
                    else if (r_held == 8'h2f && i_c == 8'h2a) n_mode = M_BLOCK;
                    else if (held_pair(r_held, i_c) != 6'd0) begin
                        e1 = 1'b1; n_mode = M_IDLE;
                        t1 = '{held_pair(r_held, i_c), r_start, t_pos'(2), 32'd0};
                    end else if (held_single(r_held) == 6'd0) begin
                        er = 1'b1;
                    end else begin
                        e1 = 1'b1; fresh = 1'b1;
                        t1 = '{held_single(r_held), r_start, t_pos'(1), 32'd0};
                    end
                end
                default: fresh = 1'b1;
            endcase
            if (fresh) begin
                n_mode = M_IDLE;
                if (is_blank(i_c)) ;
                else if (i_c == 8'h22) begin
                    n_mode = M_STRING; n_start = r_bpos + t_pos'(1);
                end else begin
                    n_start = r_bpos;
                    if (is_num(i_c)) begin
                        n_mode = M_NUMBER; n_acc = {28'd0, i_c[3:0]};
                    end else if (is_letter(i_c)) begin
                        n_mode = M_IDENT; n_word[7:0] = i_c; n_wlen = 3'd1;
                    end else if (i_c == 8'h26 || i_c == 8'h7c || held_single(i_c) != 6'd0) begin
                        n_mode = M_HELD; n_held = i_c;
                    end else if (single_kind(i_c) != 6'd0) begin
                        e2 = 1'b1; t2 = '{single_kind(i_c), r_bpos, t_pos'(1), 32'd0};
                    end else begin
                        er = 1'b1; er_pos = r_bpos;
                    end
                end
            end
            if (er) n_mode = M_DEAD;
        end
    end

    // Token limit: first emission takes priority.
    always_comb begin
        ok1 = e1 && (r_cnt < t_cnt'(TOKEN_LIMIT));
        ok2 = e2 && ((r_cnt + t_cnt'(ok1)) < t_cnt'(TOKEN_LIMIT));
        ntok = {1'b0, ok1} + {1'b0, ok2};
        n_cnt = r_cnt + t_cnt'(ntok);
        o_wr_a = ok1 || ok2 || er;
        o_wr_b = (ok1 && (ok2 || er));
        o_tok_a = '0; o_tok_b = '0;
        if (ok1)
            o_tok_a = '{1'b0, 1'b0, t1.ival, 16'(t1.len), 16'(t1.pos), t1.kind};
        else if (ok2)
            o_tok_a = '{1'b0, 1'b0, t2.ival, 16'(t2.len), 16'(t2.pos), t2.kind};
        else
            o_tok_a = '{1'b0, 1'b1, 32'd0, 16'd1, 16'(er_pos), K_EOF};
        if (ok2)
            o_tok_b = '{1'b1, 1'b0, t2.ival, 16'(t2.len), 16'(t2.pos), t2.kind};
        else
            o_tok_b = '{1'b1, 1'b1, 32'd0, 16'd1, 16'(er_pos), K_EOF};
        if (!o_wr_b) o_tok_a.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_held <= '0; r_wlen <= '0; r_start <= '0;
            r_bpos <= '0; r_acc <= '0; r_cnt <= '0;
        end else if (i_go) begin
            if (i_end) begin
                r_mode <= M_IDLE; r_held <= '0; r_wlen <= '0; r_start <= '0;
                r_bpos <= '0; r_acc <= '0; r_cnt <= '0;
            end else begin
                r_mode <= n_mode; r_held <= n_held; r_wlen <= n_wlen;
                r_start <= n_start; r_bpos <= n_bpos; r_acc <= n_acc; r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) r_word <= n_word;
    end

    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(TOKEN_LIMIT)) else $error("token count beyond limit");
    a_dead_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && r_mode == M_DEAD) |-> !o_wr_a) else $error("result after error");
    a_dead_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && !i_end && r_mode == M_DEAD) |=> r_mode == M_DEAD) else $error("left dead");
endmodule

[hdl/csharp_subset_lexer.sv]
// Top level of the C#-subset lexer: input register, lexer core, result queue.
// Depends on csl_pkg, csl_core and csl_out_buf.
`timescale 1ns / 1ps
// One source byte per word; a word is processed in the cycle after it is
// accepted and yields up to two tokens into a four-entry result queue.
// Words are taken every cycle while the queue, counting the results being
// written in that cycle, still has room for two; the sustained rate is set
// by the single master port, so a run of words that each give two tokens
// is held back by that port.
module csharp_subset_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // source_byte
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // token_kind, start_pos, text_len, int_value, lex_error
    output logic        m_axis_tlast   // last_of_run
);
    import csl_pkg::*;

    logic       r_v;
    logic       r_end;
    logic [7:0] r_c;
    logic       w_room, w_wr_a, w_wr_b;
    t_tok       w_a, w_b, w_o;

    assign s_axis_tready = w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= 1'b0;
        else          r_v <= s_axis_tvalid && s_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_end <= s_axis_tuser;
            r_c   <= s_axis_tdata;
        end
    end

    csl_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_v), .i_end(r_end), .i_c(r_c),
        .o_wr_a(w_wr_a), .o_tok_a(w_a), .o_wr_b(w_wr_b), .o_tok_b(w_b)
    );

    csl_out_buf u_buf (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_a(r_v && w_wr_a), .i_tok_a(w_a), .i_wr_b(r_v && w_wr_b), .i_tok_b(w_b),
        .o_room(w_room), .o_valid(m_axis_tvalid), .o_tok(w_o), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, w_o.err, w_o.ival, w_o.len, w_o.pos, w_o.kind};
    assign m_axis_tlast = w_o.last;
endmodule
